// File: hdl/csmh_pkg.sv
// Package: shared constants and types for the cuboid stack height block
`timescale 1ns / 1ps
`default_nettype none
package csmh_pkg;
	localparam int MAX_BOXES  = 64;
	localparam int DIM_BITS   = 16;
	localparam int IDX_BITS   = $clog2(MAX_BOXES);
	localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);
	localparam int HGT_BITS   = 22;
	localparam int BOX_BITS   = 3 * DIM_BITS;

	typedef logic [DIM_BITS-1:0] dim_t;
	typedef struct packed {
		dim_t lo;
		dim_t mid;
		dim_t hi;
	} box_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_WR,
		ST_SORT_PUT,
		ST_DP_INIT,
		ST_DP_RD,
		ST_DP_CELL,
		ST_DP_ROW,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// File: hdl/csmh_ram.sv
// Generic RAM: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module csmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: hdl/cuboid_stack_max_height_core.sv
// Top level: cuboid collection, insertion sort and take-or-skip height search
//
//  channel | direction | signals
//  in      | input     | in_valid, in_ready, dim_a, dim_b, dim_c, last_box
//  out     | output    | out_valid, out_ready, max_height, overflow
//
// A last cuboid starts an insertion sort (read, compare, write, put per element;
// compare, write per move) and a dynamic program of n(n+1)/2 cells (read, cell
// per cell; row per row), paced by the registered RAM reads. Reset clears the
// counters and the sequencer; box and row RAMs need no clearing. in_ready is low
// from the last cuboid until its result is taken.
`timescale 1ns / 1ps
`default_nettype none
module cuboid_stack_max_height_core
	import csmh_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [15:0]         dim_a,
	input  wire logic [15:0]         dim_b,
	input  wire logic [15:0]         dim_c,
	input  wire logic                last_box,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [HGT_BITS-1:0]      max_height,
	output logic                     overflow
);
	state_t state_q, state_d;
	logic [CNT_BITS-1:0] count_q;
	logic                drop_q;
	logic [CNT_BITS-1:0] i_q, j_q;
	box_t                key_q, cur_q;
	logic [HGT_BITS-1:0] res_q;
	logic [HGT_BITS:0]   rnext_q;
	logic                first_q;
	logic [CNT_BITS-1:0] idx_q, p_q;

	logic                ram_we;
	logic [IDX_BITS-1:0] ram_wa, ram_ra;
	box_t                ram_wd, ram_rd;

	logic                row_we;
	logic [CNT_BITS-1:0] row_wa, row_ra;
	logic [HGT_BITS:0]   row_rd;
	logic [HGT_BITS:0]   take, skip, best;

	csmh_ram #(.WIDTH(BOX_BITS), .DEPTH(MAX_BOXES)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	csmh_ram #(.WIDTH(HGT_BITS + 1), .DEPTH(MAX_BOXES + 1)) u_row_ram (
		.clk(clk), .we(row_we), .waddr(row_wa), .wdata(best),
		.raddr(row_ra), .rdata(row_rd)
	);

	dim_t a0, b0, c0, t1, t2, s0, s1, s2;
	always_comb begin
		a0 = dim_a[DIM_BITS-1:0];
		b0 = dim_b[DIM_BITS-1:0];
		c0 = dim_c[DIM_BITS-1:0];
		if (a0 > b0) begin t1 = b0; t2 = a0; end
		else begin t1 = a0; t2 = b0; end
		if (t2 > c0) begin s2 = t2; s1 = c0; end
		else begin s2 = c0; s1 = t2; end
		if (t1 > s1) begin s0 = s1; s1 = t1; end
		else s0 = t1;
	end

	wire in_acc  = in_valid && in_ready;
	wire out_acc = out_valid && out_ready;
	wire full    = count_q == CNT_BITS'(MAX_BOXES);
	wire prev_after = (ram_rd.lo != key_q.lo) ? (ram_rd.lo > key_q.lo) :
		(ram_rd.mid != key_q.mid) ? (ram_rd.mid > key_q.mid) :
		(ram_rd.hi > key_q.hi);
	wire fits = (p_q == '0) || (ram_rd.lo <= cur_q.lo && ram_rd.mid <= cur_q.mid &&
		ram_rd.hi <= cur_q.hi);
	always_comb begin
		take = fits ? ({{(HGT_BITS+1-DIM_BITS){1'b0}}, cur_q.hi} + rnext_q) : '0;
		skip = first_q ? '0 : row_rd;
		best = (take > skip) ? take : skip;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (in_acc && last_box) state_d = ST_SORT_RD;
			ST_SORT_RD: state_d = (i_q >= count_q) ? ST_DP_INIT : ST_SORT_CMP;
			ST_SORT_CMP: state_d = ST_SORT_WR;
			ST_SORT_WR: state_d = (j_q != '0 && prev_after) ? ST_SORT_CMP : ST_SORT_PUT;
			ST_SORT_PUT: state_d = ST_SORT_RD;
			ST_DP_INIT: state_d = (count_q == '0) ? ST_OUT : ST_DP_ROW;
			ST_DP_ROW: state_d = ST_DP_RD;
			ST_DP_RD: state_d = ST_DP_CELL;
			ST_DP_CELL: state_d = (p_q != '0) ? ST_DP_RD :
				(idx_q == '0) ? ST_OUT : ST_DP_ROW;
			ST_OUT: if (out_acc) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready  = state_q == ST_LOAD;
		out_valid = state_q == ST_OUT;
		ram_we = 1'b0;
		ram_wa = count_q[IDX_BITS-1:0];
		ram_wd = '{lo: s0, mid: s1, hi: s2};
		ram_ra = '0;
		row_we = state_q == ST_DP_CELL;
		row_wa = p_q;
		row_ra = '0;
		case (state_q)
			ST_LOAD: ram_we = in_acc && !full;
			ST_SORT_RD: ram_ra = i_q[IDX_BITS-1:0];
			ST_SORT_CMP: ram_ra = IDX_BITS'(j_q - 1'b1);
			ST_SORT_WR: begin
				ram_we = j_q != '0 && prev_after;
				ram_wa = j_q[IDX_BITS-1:0];
				ram_wd = ram_rd;
			end
			ST_SORT_PUT: begin
				ram_we = 1'b1;
				ram_wa = j_q[IDX_BITS-1:0];
				ram_wd = key_q;
			end
			ST_DP_ROW: begin
				ram_ra = idx_q[IDX_BITS-1:0];
				row_ra = CNT_BITS'(idx_q + 1'b1);
			end
			ST_DP_RD: begin
				ram_ra = IDX_BITS'(p_q - 1'b1);
				row_ra = p_q;
			end
			default: ram_ra = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			idx_q <= '0;
			p_q <= '0;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: if (in_acc) begin
					if (full) drop_q <= 1'b1;
					else count_q <= count_q + 1'b1;
					i_q <= CNT_BITS'(1);
				end
				ST_SORT_RD: j_q <= i_q;
				ST_SORT_WR: if (j_q != '0 && prev_after) j_q <= j_q - 1'b1;
				ST_SORT_PUT: i_q <= i_q + 1'b1;
				ST_DP_INIT: begin
					idx_q   <= count_q - 1'b1;
					first_q <= 1'b1;
				end
				ST_DP_ROW: p_q <= idx_q;
				ST_DP_CELL: if (p_q != '0) begin
					p_q <= p_q - 1'b1;
				end else begin
					idx_q   <= idx_q - 1'b1;
					first_q <= 1'b0;
				end
				ST_OUT: if (out_acc) begin
					count_q <= '0;
					drop_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SORT_CMP: if (j_q == i_q) key_q <= ram_rd;
			ST_DP_INIT: res_q <= '0;
			ST_DP_RD: if (p_q == idx_q) begin
				cur_q   <= ram_rd;
				rnext_q <= first_q ? '0 : row_rd;
			end
			ST_DP_CELL: if (p_q == '0 && idx_q == '0) begin
				res_q <= best[HGT_BITS] ? {HGT_BITS{1'b1}} : best[HGT_BITS-1:0];
			end
			default: ;
		endcase
	end

	assign max_height = res_q;
	assign overflow   = drop_q;

	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready and valid together");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(MAX_BOXES)) else $error("count beyond capacity");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |=> (count_q == '0 && !drop_q)) else $error("set not emptied");
endmodule
`default_nettype wire
